// ===== sv/puf_pkg.sv =====
// Shared types, codes, stage map and arithmetic helpers for the pixel unpremultiply block.
package puf_pkg;

  localparam logic [7:0] CH_MAX = 8'd255;

  // Stored pixel layouts selected by the source_layout register.
  typedef enum logic [1:0] {
    LAYOUT_PREMUL_BGRA = 2'd0,
    LAYOUT_BGRA        = 2'd1,
    LAYOUT_RGBA        = 2'd2,
    LAYOUT_GRAY        = 2'd3
  } layout_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_SOURCE_LAYOUT    = 2'd0,
    REG_KEEP_ALPHA       = 2'd1,
    REG_BACKGROUND_COLOR = 2'd2
  } cfg_reg_t;

  // Pipeline stage map.
  localparam int NSTG        = 24;
  localparam int U_DIV_FIRST = 1;
  localparam int U_DIV_LAST  = 8;
  localparam int F_FINISH    = 9;
  localparam int F_MUL       = 10;
  localparam int F_MUL_BG    = 11;
  localparam int F_EST       = 12;
  localparam int F_FIX       = 13;
  localparam int F_SUM       = 14;
  localparam int F_DIV_FIRST = 15;
  localparam int F_DIV_LAST  = 22;
  localparam int F_OUT       = NSTG - 1;

  // Payload carried by every pipeline stage; channel 0 is red, 1 green, 2 blue.
  typedef struct packed {
    logic             fin;
    logic [2:0][7:0]  col;
    logic [7:0]       alp;
    logic             dvd;
    logic [7:0]       den;
    logic [2:0][8:0]  rem;
    logic [2:0][7:0]  low;
    logic [2:0][7:0]  quo;
    logic [2:0]       sat;
    logic [2:0][15:0] ps;
    logic [2:0][23:0] pd;
    logic [2:0][16:0] pq;
    logic [15:0]      pa;
    logic [16:0]      paq;
    logic [7:0]       inv;
  } stage_t;

  // One restoring division step: returns {quotient bit, new remainder}.
  function automatic logic [8:0] div_step(logic [8:0] rem, logic in_bit, logic [7:0] den);
    logic [8:0] t;
    logic [8:0] d;
    t = {rem[7:0], in_bit};
    d = {1'b0, den};
    if (t >= d) begin
      return {1'b1, 8'(t - d)};
    end
    return {1'b0, t[7:0]};
  endfunction

  // Lower estimate of x / 255, at most one below the true quotient.
  function automatic logic [16:0] div255_est(logic [23:0] x);
    logic [24:0] s;
    s = {1'b0, x} + 25'(x >> 8) + 25'(x >> 16);
    return s[24:8];
  endfunction

  // Corrects the estimate with one compare against the remainder.
  function automatic logic [16:0] div255_fix(logic [23:0] x, logic [16:0] q);
    logic [25:0] r;
    r = {2'b00, x} + {9'b0, q} - {1'b0, q, 8'b0};
    if (r >= 26'd255) begin
      return q + 17'd1;
    end
    return q;
  endfunction

endpackage

// ===== sv/puf_if.sv =====
// Valid/ready channel interfaces for pixels in and results out.
interface puf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_zero;
  logic [7:0] byte_one;
  logic [7:0] byte_two;
  logic [7:0] byte_three;
  logic       final_pixel;

  modport source (output valid, byte_zero, byte_one, byte_two, byte_three, final_pixel,
                  input ready);
  modport sink (input valid, byte_zero, byte_one, byte_two, byte_three, final_pixel,
                output ready);
endinterface

interface puf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic [7:0] alpha_out;
  logic       final_out;

  modport source (output valid, red_out, green_out, blue_out, alpha_out, final_out,
                  input ready);
  modport sink (input valid, red_out, green_out, blue_out, alpha_out, final_out,
                output ready);
endinterface

// ===== sv/pixel_unpremultiply_and_flatten.sv =====
// Top level: pipelined pixel unpremultiply and background flatten.
//
//  channel     kind          direction  contents
//  pixel_in    valid/ready   in         four stored bytes and last-pixel flag
//  pixel_out   valid/ready   out        straight or flattened RGBA and last flag
//  cfg_*       write port    in         source_layout, keep_alpha, background_color
//
// One item can enter every cycle while the output is not stalled; an item passes
// through the stage registers to the output register, a depth set mostly by the two eight-step dividers.
// Reset (rst, synchronous) clears the stage valid bits and loads the register
// defaults: RGBA layout, alpha kept, black transparent background.
// A full stage holds its item while the next one is stalled, so bubbles close
// up and the input stalls only when all 24 stages are full and the output waits.
module pixel_unpremultiply_and_flatten (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [1:0]       cfg_index,
  input  logic [31:0]      cfg_data,
  puf_in_if.sink           pixel_in,
  puf_out_if.source        pixel_out
);

  // Configuration registers.
  puf_pkg::layout_t source_layout;
  logic             keep_alpha;
  logic [31:0]      background_color;

  // Pipeline state: one valid bit and one payload register per stage.
  logic [puf_pkg::NSTG-1:0] vld;
  logic [puf_pkg::NSTG-1:0] adv;
  puf_pkg::stage_t          st  [puf_pkg::NSTG];
  puf_pkg::stage_t          nxt [puf_pkg::NSTG];
  puf_pkg::stage_t          dec;

  // Background channels split out of the ARGB word.
  logic [7:0]      bg_a;
  logic [2:0][7:0] bg_c;

  assign bg_a    = background_color[31:24];
  assign bg_c[0] = background_color[23:16];
  assign bg_c[1] = background_color[15:8];
  assign bg_c[2] = background_color[7:0];

  // Configuration writes; an index past the register list is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      source_layout    <= puf_pkg::LAYOUT_RGBA;
      keep_alpha       <= 1'b1;
      background_color <= 32'd0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        puf_pkg::REG_SOURCE_LAYOUT:    source_layout    <= puf_pkg::layout_t'(cfg_data[1:0]);
        puf_pkg::REG_KEEP_ALPHA:       keep_alpha       <= cfg_data[0];
        puf_pkg::REG_BACKGROUND_COLOR: background_color <= cfg_data;
        default: ;
      endcase
    end
  end

  // A stage may load when it is empty or its item moves on in the same cycle.
  always_comb begin
    adv[puf_pkg::NSTG-1] = !vld[puf_pkg::NSTG-1] || pixel_out.ready;
    for (int k = puf_pkg::NSTG - 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign pixel_in.ready = adv[0];

  // Stage 0: decode the stored layout and form the unpremultiply dividends
  // v*255 + a/2. The division is only used for premultiplied pixels whose
  // alpha is neither 0 nor 255; alpha 0 forces black right here.
  always_comb begin : decode_stage
    puf_pkg::stage_t n;
    logic [15:0]     num;
    n = '0;
    n.fin = pixel_in.final_pixel;
    n.alp = pixel_in.byte_three;
    case (source_layout)
      puf_pkg::LAYOUT_PREMUL_BGRA, puf_pkg::LAYOUT_BGRA: begin
        n.col[0] = pixel_in.byte_two;
        n.col[1] = pixel_in.byte_one;
        n.col[2] = pixel_in.byte_zero;
      end
      puf_pkg::LAYOUT_RGBA: begin
        n.col[0] = pixel_in.byte_zero;
        n.col[1] = pixel_in.byte_one;
        n.col[2] = pixel_in.byte_two;
      end
      default: begin
        n.col[0] = pixel_in.byte_zero;
        n.col[1] = pixel_in.byte_zero;
        n.col[2] = pixel_in.byte_zero;
        n.alp    = puf_pkg::CH_MAX;
      end
    endcase
    n.den = n.alp;
    for (int c = 0; c < 3; c++) begin
      num      = {n.col[c], 8'd0} - {8'd0, n.col[c]} + {9'd0, n.alp[7:1]};
      n.rem[c] = {1'b0, num[15:8]};
      n.low[c] = num[7:0];
    end
    n.dvd = (source_layout == puf_pkg::LAYOUT_PREMUL_BGRA) &&
            (n.alp != 8'd0) && (n.alp != puf_pkg::CH_MAX);
    if ((source_layout == puf_pkg::LAYOUT_PREMUL_BGRA) && (n.alp == 8'd0)) begin
      n.col = '0;
    end
    dec = n;
  end

  // Stages 1 to 23. Both divisions share the same step logic: the first step
  // of each divider also decides saturation, which happens exactly when the
  // upper dividend bits already reach the divisor.
  always_comb begin : stage_logic
    puf_pkg::stage_t p;
    puf_pkg::stage_t n;
    logic [8:0]      qs;
    logic [16:0]     sum;
    logic            is_div;
    logic            is_first;
    nxt[0] = dec;
    for (int k = 1; k < puf_pkg::NSTG; k++) begin
      p = st[k-1];
      n = p;
      is_div   = ((k >= puf_pkg::U_DIV_FIRST) && (k <= puf_pkg::U_DIV_LAST)) ||
                 ((k >= puf_pkg::F_DIV_FIRST) && (k <= puf_pkg::F_DIV_LAST));
      is_first = (k == puf_pkg::U_DIV_FIRST) || (k == puf_pkg::F_DIV_FIRST);
      if (is_div) begin
        for (int c = 0; c < 3; c++) begin
          if (is_first) begin
            n.sat[c] = p.rem[c] >= {1'b0, p.den};
          end
          qs       = puf_pkg::div_step(p.rem[c], p.low[c][7], p.den);
          n.rem[c] = {1'b0, qs[7:0]};
          n.low[c] = {p.low[c][6:0], 1'b0};
          n.quo[c] = {p.quo[c][6:0], qs[8]};
        end
      end else begin
        case (k)
          puf_pkg::F_FINISH: begin
            // Straight color is settled; start the source-over terms.
            for (int c = 0; c < 3; c++) begin
              if (p.dvd) begin
                n.col[c] = p.sat[c] ? puf_pkg::CH_MAX : p.quo[c];
              end
            end
            n.inv = puf_pkg::CH_MAX - p.alp;
          end
          puf_pkg::F_MUL: begin
            for (int c = 0; c < 3; c++) begin
              n.ps[c] = 16'(p.col[c]) * 16'(p.alp);
            end
            n.pa = 16'(bg_a) * 16'(p.inv);
          end
          puf_pkg::F_MUL_BG: begin
            for (int c = 0; c < 3; c++) begin
              n.pd[c] = 24'(bg_c[c]) * 24'(p.pa);
            end
            n.paq = puf_pkg::div255_est(24'(p.pa));
          end
          puf_pkg::F_EST: begin
            for (int c = 0; c < 3; c++) begin
              n.pq[c] = puf_pkg::div255_est(p.pd[c]);
            end
            n.paq = puf_pkg::div255_fix(24'(p.pa), p.paq);
          end
          puf_pkg::F_FIX: begin
            for (int c = 0; c < 3; c++) begin
              n.pq[c] = puf_pkg::div255_fix(p.pd[c], p.pq[c]);
            end
          end
          puf_pkg::F_SUM: begin
            // Result alpha never exceeds 255, so eight bits hold it.
            n.den = p.alp + p.paq[7:0];
            for (int c = 0; c < 3; c++) begin
              sum      = {1'b0, p.ps[c]} + p.pq[c];
              n.rem[c] = sum[16:8];
              n.low[c] = sum[7:0];
              n.quo[c] = 8'd0;
            end
          end
          puf_pkg::F_OUT: begin
            if (!keep_alpha) begin
              for (int c = 0; c < 3; c++) begin
                if (p.den == 8'd0) begin
                  n.col[c] = 8'd0;
                end else begin
                  n.col[c] = p.sat[c] ? puf_pkg::CH_MAX : p.quo[c];
                end
              end
              n.alp = 8'd0;
            end
          end
          default: ;
        endcase
      end
      nxt[k] = n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= pixel_in.valid;
      end
      for (int k = 1; k < puf_pkg::NSTG; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < puf_pkg::NSTG; k++) begin
      if (adv[k]) begin
        st[k] <= nxt[k];
      end
    end
  end

  assign pixel_out.valid     = vld[puf_pkg::F_OUT];
  assign pixel_out.red_out   = st[puf_pkg::F_OUT].col[0];
  assign pixel_out.green_out = st[puf_pkg::F_OUT].col[1];
  assign pixel_out.blue_out  = st[puf_pkg::F_OUT].col[2];
  assign pixel_out.alpha_out = st[puf_pkg::F_OUT].alp;
  assign pixel_out.final_out = st[puf_pkg::F_OUT].fin;

`ifndef NO_ASSERTIONS
  // The input only backs up once every stage holds an item.
  a_full_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !pixel_in.ready |-> (&vld))
    else $error("input stalled while a pipeline stage is empty");

  // Items move one stage at a time: occupancy changes by at most one per cycle.
  a_occupancy_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |->
      ($countones(vld) == $countones($past(vld))) ||
      ($countones(vld) == $countones($past(vld)) + 1) ||
      ($countones(vld) + 1 == $countones($past(vld))))
    else $error("pipeline occupancy jumped");

  // Unsaturated unpremultiply lanes end with a remainder below the divisor.
  a_unpremul_rem: assert property (@(posedge clk) disable iff (rst)
    vld[puf_pkg::U_DIV_LAST] && (st[puf_pkg::U_DIV_LAST].den != 8'd0) |->
      (st[puf_pkg::U_DIV_LAST].sat[0] ||
       (st[puf_pkg::U_DIV_LAST].rem[0] < {1'b0, st[puf_pkg::U_DIV_LAST].den})) &&
      (st[puf_pkg::U_DIV_LAST].sat[1] ||
       (st[puf_pkg::U_DIV_LAST].rem[1] < {1'b0, st[puf_pkg::U_DIV_LAST].den})) &&
      (st[puf_pkg::U_DIV_LAST].sat[2] ||
       (st[puf_pkg::U_DIV_LAST].rem[2] < {1'b0, st[puf_pkg::U_DIV_LAST].den})))
    else $error("unpremultiply divider remainder out of range");

  // Same invariant for the flatten divider.
  a_flatten_rem: assert property (@(posedge clk) disable iff (rst)
    vld[puf_pkg::F_DIV_LAST] && (st[puf_pkg::F_DIV_LAST].den != 8'd0) |->
      (st[puf_pkg::F_DIV_LAST].sat[0] ||
       (st[puf_pkg::F_DIV_LAST].rem[0] < {1'b0, st[puf_pkg::F_DIV_LAST].den})) &&
      (st[puf_pkg::F_DIV_LAST].sat[1] ||
       (st[puf_pkg::F_DIV_LAST].rem[1] < {1'b0, st[puf_pkg::F_DIV_LAST].den})) &&
      (st[puf_pkg::F_DIV_LAST].sat[2] ||
       (st[puf_pkg::F_DIV_LAST].rem[2] < {1'b0, st[puf_pkg::F_DIV_LAST].den})))
    else $error("flatten divider remainder out of range");
`endif

endmodule

// ===== tb/pixel_unpremultiply_and_flatten_checker.sv =====
// Result checker: mirrors the register file, predicts each pixel and compares block output.
module pixel_unpremultiply_and_flatten_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  puf_in_if           pixel_in,
  puf_out_if          pixel_out,
  output int          error_count,
  output int          outstanding,
  output int          results_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last;
  } rgba_t;

  puf_pkg::layout_t layout_reg;
  logic             keep_alpha_reg;
  logic [31:0]      background_reg;
  rgba_t            expected_pixels[$];

  // Rounded division of a premultiplied channel by its alpha, clamped at full scale.
  function automatic logic [7:0] unpremultiply(logic [7:0] v, logic [7:0] a);
    int unsigned q;
    if (a == 8'd0) return 8'd0;
    if (a == puf_pkg::CH_MAX) return v;
    q = (32'(v) * 32'(puf_pkg::CH_MAX) + 32'(a >> 1)) / 32'(a);
    return (q > 32'(puf_pkg::CH_MAX)) ? puf_pkg::CH_MAX : q[7:0];
  endfunction

  // Source-over onto the background with truncating division, clamped at full scale.
  function automatic logic [7:0] flatten(logic [7:0] src, logic [7:0] dst,
                                         logic [7:0] sa, logic [7:0] da);
    int unsigned out_alpha;
    int unsigned q;
    out_alpha = 32'(sa) + 32'(da) * (32'(puf_pkg::CH_MAX) - 32'(sa)) / 32'(puf_pkg::CH_MAX);
    if (out_alpha == 0) return 8'd0;
    q = (32'(src) * 32'(sa)
         + 32'(dst) * 32'(da) * (32'(puf_pkg::CH_MAX) - 32'(sa)) / 32'(puf_pkg::CH_MAX))
        / out_alpha;
    return (q > 32'(puf_pkg::CH_MAX)) ? puf_pkg::CH_MAX : q[7:0];
  endfunction

  function automatic rgba_t convert_pixel(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                                          logic [7:0] b3, logic last);
    rgba_t p;
    p.last = last;
    case (layout_reg)
      puf_pkg::LAYOUT_PREMUL_BGRA: begin
        p.alpha = b3;
        p.blue  = unpremultiply(b0, b3);
        p.green = unpremultiply(b1, b3);
        p.red   = unpremultiply(b2, b3);
      end
      puf_pkg::LAYOUT_BGRA: begin
        p.blue  = b0;
        p.green = b1;
        p.red   = b2;
        p.alpha = b3;
      end
      puf_pkg::LAYOUT_RGBA: begin
        p.red   = b0;
        p.green = b1;
        p.blue  = b2;
        p.alpha = b3;
      end
      default: begin
        p.red   = b0;
        p.green = b0;
        p.blue  = b0;
        p.alpha = puf_pkg::CH_MAX;
      end
    endcase
    if (!keep_alpha_reg) begin
      p.red   = flatten(p.red,   background_reg[23:16], p.alpha, background_reg[31:24]);
      p.green = flatten(p.green, background_reg[15:8],  p.alpha, background_reg[31:24]);
      p.blue  = flatten(p.blue,  background_reg[7:0],   p.alpha, background_reg[31:24]);
      p.alpha = 8'd0;
    end
    return p;
  endfunction

  always @(posedge clk) begin
    rgba_t want;
    rgba_t got;
    rgba_t pred;
    if (rst) begin
      layout_reg     = puf_pkg::LAYOUT_RGBA;
      keep_alpha_reg = 1'b1;
      background_reg = 32'h0;
      expected_pixels.delete();
    end else begin
      if (pixel_out.valid && pixel_out.ready) begin
        got.red   = pixel_out.red_out;
        got.green = pixel_out.green_out;
        got.blue  = pixel_out.blue_out;
        got.alpha = pixel_out.alpha_out;
        got.last  = pixel_out.final_out;
        if (expected_pixels.size() == 0) begin
          error_count = error_count + 1;
          $display("%0t ns: result with none expected: R %0d G %0d B %0d A %0d last %0b",
                   $time, got.red, got.green, got.blue, got.alpha, got.last);
        end else begin
          want = expected_pixels.pop_front();
          results_checked = results_checked + 1;
          if (got !== want) begin
            error_count = error_count + 1;
            $display("%0t ns: mismatch: expected %0d/%0d/%0d/%0d/%0b got %0d/%0d/%0d/%0d/%0b",
                     $time, want.red, want.green, want.blue, want.alpha, want.last,
                     got.red, got.green, got.blue, got.alpha, got.last);
          end
        end
      end
      if (pixel_in.valid && pixel_in.ready) begin
        pred = convert_pixel(pixel_in.byte_zero, pixel_in.byte_one,
                             pixel_in.byte_two, pixel_in.byte_three,
                             pixel_in.final_pixel);
        expected_pixels = {expected_pixels, pred};
      end
      if (cfg_write) begin
        case (cfg_index)
          puf_pkg::REG_SOURCE_LAYOUT:    layout_reg     = puf_pkg::layout_t'(cfg_data[1:0]);
          puf_pkg::REG_KEEP_ALPHA:       keep_alpha_reg = cfg_data[0];
          puf_pkg::REG_BACKGROUND_COLOR: background_reg = cfg_data;
          default: ;
        endcase
      end
    end
    outstanding = expected_pixels.size();
  end

endmodule

// ===== tb/pixel_unpremultiply_and_flatten_tb.sv =====
// Testbench top: drives pixels and register writes into the block and gives the verdict.
module pixel_unpremultiply_and_flatten_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // The run is bounded far above the slowest legal run (about 1100 pixels under heavy
  // receiver idling, plus drains and one long hold-off).
  localparam int CYCLE_LIMIT    = 400000;
  localparam int HOLD_CYCLES    = 80;
  localparam int SEGMENTS       = 6;
  localparam int SEGMENT_PIXELS = 60;
  localparam int DRAIN_CYCLES   = 30;
  // Index past the end of the register list; writes there must be ignored.
  localparam logic [1:0] REG_UNUSED = 2'd3;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = 2'd0;
  logic [31:0] cfg_data  = 32'h0;

  puf_in_if  pixel_in();
  puf_out_if pixel_out();

  int               error_count;
  int               outstanding;
  int               results_checked;
  int               send_idle      = 29;
  int               recv_idle      = 78;
  int               settings_count = 0;
  logic             hold_req       = 1'b0;
  puf_pkg::layout_t cur_layout     = puf_pkg::LAYOUT_RGBA;

  pixel_unpremultiply_and_flatten dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixel_in  (pixel_in),
    .pixel_out (pixel_out)
  );

  pixel_unpremultiply_and_flatten_checker result_check (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .pixel_in        (pixel_in),
    .pixel_out       (pixel_out),
    .error_count     (error_count),
    .outstanding     (outstanding),
    .results_checked (results_checked)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // The receiver changes ready only at falling edges. A hold-off request makes it
  // keep ready low for a long stretch, once, so the pipeline fills and the input stalls.
  initial begin
    logic hold_done;
    hold_done = 1'b0;
    pixel_out.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        pixel_out.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      pixel_out.ready = ($urandom_range(99) >= recv_idle);
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

  // Byte values weighted toward the ends of the range.
  function automatic logic [7:0] rand_byte();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Offers one item starting at a falling edge, after a random number of idle
  // cycles, and returns at the falling edge that follows its acceptance. Valid
  // stays high when the next item follows at once.
  task automatic send_pixel(input logic [7:0] b0, input logic [7:0] b1,
                            input logic [7:0] b2, input logic [7:0] b3, input logic last);
    while ($urandom_range(99) < send_idle) begin
      pixel_in.valid = 1'b0;
      @(negedge clk);
    end
    pixel_in.valid       = 1'b1;
    pixel_in.byte_zero   = b0;
    pixel_in.byte_one    = b1;
    pixel_in.byte_two    = b2;
    pixel_in.byte_three  = b3;
    pixel_in.final_pixel = last;
    do @(posedge clk); while (!pixel_in.ready);
    @(negedge clk);
  endtask

  // Every item yields exactly one result, so the block is idle once the checker
  // has nothing outstanding.
  task automatic drain();
    pixel_in.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // Leaves the write enable high; the caller lowers it after its last write.
  task automatic write_reg(input logic [1:0] index, input logic [31:0] data);
    cfg_write = 1'b1;
    cfg_index = index;
    cfg_data  = data;
    @(negedge clk);
  endtask

  task automatic set_config(input puf_pkg::layout_t layout, input logic keep,
                            input logic [31:0] bg);
    drain();
    write_reg(puf_pkg::REG_SOURCE_LAYOUT, 32'(layout));
    write_reg(puf_pkg::REG_KEEP_ALPHA, 32'(keep));
    write_reg(puf_pkg::REG_BACKGROUND_COLOR, bg);
    cfg_write = 1'b0;
    cur_layout = layout;
    settings_count = settings_count + 1;
  endtask

  initial begin
    logic [7:0]  ch[3];
    logic [7:0]  alpha;
    logic [31:0] bg;
    logic        last;
    pixel_in.valid       = 1'b0;
    pixel_in.byte_zero   = 8'h00;
    pixel_in.byte_one    = 8'h00;
    pixel_in.byte_two    = 8'h00;
    pixel_in.byte_three  = 8'h00;
    pixel_in.final_pixel = 1'b0;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    // Directed part. The reset defaults (RGBA, alpha kept) come first.
    send_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    send_pixel(8'h12, 8'h34, 8'h56, 8'h78, 1'b0);

    // Premultiplied input: zero alpha clears the color, full alpha passes it through,
    // channels above alpha saturate, and mid alphas exercise the rounding.
    set_config(puf_pkg::LAYOUT_PREMUL_BGRA, 1'b1, 32'h0);
    send_pixel(8'hFF, 8'h80, 8'h01, 8'h00, 1'b0);
    send_pixel(8'h12, 8'h34, 8'h56, 8'hFF, 1'b0);
    send_pixel(8'hFF, 8'hC8, 8'h10, 8'h01, 1'b0);
    send_pixel(8'h01, 8'h02, 8'h7F, 8'h80, 1'b0);
    send_pixel(8'h40, 8'h3F, 8'h41, 8'h81, 1'b1);

    set_config(puf_pkg::LAYOUT_BGRA, 1'b1, 32'hFFFF_FFFF);
    send_pixel(8'h11, 8'h22, 8'h33, 8'h44, 1'b0);

    // Gray ignores the upper three bytes and reports full alpha.
    set_config(puf_pkg::LAYOUT_GRAY, 1'b1, 32'h0);
    send_pixel(8'hAB, 8'hFF, 8'h00, 8'h55, 1'b0);
    // A write past the end of the register list must leave the layout at gray.
    drain();
    write_reg(REG_UNUSED, 32'h0);
    cfg_write = 1'b0;
    send_pixel(8'h00, 8'h12, 8'hFF, 8'h00, 1'b1);

    // Flattening onto a transparent background with a transparent pixel has zero
    // result alpha, so every channel comes out zero.
    set_config(puf_pkg::LAYOUT_RGBA, 1'b0, 32'h0);
    send_pixel(8'hFF, 8'h80, 8'h40, 8'h00, 1'b0);
    set_config(puf_pkg::LAYOUT_RGBA, 1'b0, 32'hFFFF_FFFF);
    send_pixel(8'h10, 8'h20, 8'h30, 8'h00, 1'b0);
    send_pixel(8'h00, 8'h80, 8'hFF, 8'h80, 1'b0);
    // A nearly transparent white pixel on a nearly transparent white background
    // overflows the quotient, which must clamp.
    set_config(puf_pkg::LAYOUT_RGBA, 1'b0, 32'h01FF_FFFF);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 8'h01, 1'b1);
    set_config(puf_pkg::LAYOUT_GRAY, 1'b0, 32'h8020_4060);
    send_pixel(8'h9C, 8'h00, 8'h00, 8'h00, 1'b0);
    set_config(puf_pkg::LAYOUT_PREMUL_BGRA, 1'b0, 32'h8020_4060);
    send_pixel(8'h30, 8'h60, 8'h7F, 8'h80, 1'b0);
    send_pixel(8'hFF, 8'h00, 8'h90, 8'h40, 1'b1);

    // Random part in three idling phases. Each phase starts with extreme register
    // settings and continues with random ones.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin send_idle = 29; recv_idle = 78; end
        1:       begin send_idle = 78; recv_idle = 29; end
        default: begin send_idle = 0;  recv_idle = 0;  end
      endcase
      for (int seg = 0; seg < SEGMENTS; seg++) begin
        case ($urandom_range(4))
          0:       bg = 32'h0000_0000;
          1:       bg = 32'hFFFF_FFFF;
          2:       bg = {8'hFF, 24'($urandom)};
          3:       bg = {8'h00, 24'($urandom)};
          default: bg = $urandom;
        endcase
        case (seg)
          0:       set_config(puf_pkg::LAYOUT_PREMUL_BGRA, 1'b0, 32'hFFFF_FFFF);
          1:       set_config(puf_pkg::LAYOUT_GRAY, 1'b1, 32'h0);
          2:       set_config(puf_pkg::LAYOUT_BGRA, 1'b0, 32'h0);
          default: set_config(puf_pkg::layout_t'($urandom_range(3)),
                              $urandom_range(2) == 0, bg);
        endcase
        // With no idling on either side, a long receiver hold-off backs the
        // pipeline up while the sender keeps offering items.
        if (phase == 2 && seg == 1) hold_req = 1'b1;
        for (int n = 0; n < SEGMENT_PIXELS; n++) begin
          case ($urandom_range(7))
            0:       alpha = 8'h00;
            1:       alpha = 8'hFF;
            2:       alpha = 8'h01;
            3:       alpha = 8'($urandom_range(8));
            default: alpha = 8'($urandom_range(255));
          endcase
          // Premultiplied data is mostly well formed (channels at most alpha);
          // the rest has channels above alpha to reach the clamp.
          for (int k = 0; k < 3; k++) begin
            if (cur_layout == puf_pkg::LAYOUT_PREMUL_BGRA && $urandom_range(9) != 0)
              ch[k] = 8'($urandom_range(alpha));
            else
              ch[k] = rand_byte();
          end
          last = (n == SEGMENT_PIXELS - 1) || ($urandom_range(15) == 0);
          send_pixel(ch[0], ch[1], ch[2], alpha, last);
        end
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Checked %0d pixel results over %0d register settings: all four layouts,",
             results_checked, settings_count);
    $display("alpha kept and flattened, idling 29/78, 78/29, 0/0 and a %0d-cycle hold-off.",
             HOLD_CYCLES);
    if (error_count == 0 && outstanding == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
